// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and small helper functions of the tile constraint
// collapse engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_HEIGHT = 16;
  localparam int MAX_TILES  = 16;
  localparam int MAX_CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int TW         = $clog2(MAX_TILES);
  localparam int AW         = $clog2(MAX_CELLS);
  localparam int NW         = AW + 1;
  localparam int MW         = 16;
  localparam int CW         = 5;
  localparam int DIMW       = 5;
  localparam int SEEDW      = 32;
  localparam int NDIR       = 4;

  localparam logic [1:0] FUNC_RULE     = 2'd0;
  localparam logic [1:0] FUNC_CLEAR    = 2'd1;
  localparam logic [1:0] FUNC_COLLAPSE = 2'd2;
  localparam logic [1:0] FUNC_READ     = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TILES  = 2'd2;
  localparam logic [1:0] CFG_SEED   = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [DIMW-1:0] RST_WIDTH  = 5'd10;
  localparam logic [DIMW-1:0] RST_HEIGHT = 5'd10;
  localparam logic [DIMW-1:0] RST_TILES  = 5'd16;
  localparam logic [SEEDW-1:0] RST_SEED  = 32'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  rule_tile;
    logic [1:0]  rule_dir;
    logic [15:0] rule_mask;
    logic [7:0]  read_cell;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  cell_out;
    logic [3:0]  tile_out;
    logic [15:0] mask_out;
    logic [4:0]  count_out;
    logic        all_collapsed;
    logic        contradiction;
  } out_res_t;

  typedef struct packed {
    logic [YW-1:0] y;
    logic [XW-1:0] x;
  } xy_t;

  typedef enum logic [1:0] {
    SCAN_CLEAR,
    SCAN_MIN,
    SCAN_PICK,
    SCAN_DONE
  } scan_mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RULE,
    ST_CLR_GO,
    ST_CLR,
    ST_MIN_GO,
    ST_MIN,
    ST_RND1,
    ST_MOD1,
    ST_PICK_GO,
    ST_PICK,
    ST_RND2,
    ST_MOD2,
    ST_KTH_GO,
    ST_KTH,
    ST_FIX,
    ST_POP,
    ST_POPQ,
    ST_POPC,
    ST_ADJ,
    ST_DIR,
    ST_CHILD,
    ST_RD,
    ST_RDW,
    ST_DONE_GO,
    ST_DONE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       rule_wr;
    logic       clear_fin;
    logic       rnd1;
    logic       rnd2;
    logic       pick_load;
    logic       kth_load;
    logic       kth_step;
    logic       fix;
    logic       pop_issue;
    logic       pop_take;
    logic       adj_start;
    logic       child_issue;
    logic       child_update;
    logic       dir_next;
    logic       rd_issue;
    logic       rd_take;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic mod_busy;
    logic adj_busy;
    logic kth_last;
    logic q_empty;
    logic nb_ok;
    logic dir_last;
    logic child_zero;
    logic collapse_none;
    logic out_free;
  } sts_t;

  function automatic logic [SEEDW-1:0] xorshift32(input logic [SEEDW-1:0] s);
    logic [SEEDW-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [CW-1:0] popcount16(input logic [MW-1:0] m);
    logic [CW-1:0] n;
    n = '0;
    for (int i = 0; i < MW; i++) begin
      n = n + CW'(m[i]);
    end
    return n;
  endfunction

  function automatic logic [TW-1:0] lowest_bit(input logic [MW-1:0] m);
    logic [TW-1:0] b;
    b = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (m[i]) begin
        b = TW'(i);
      end
    end
    return b;
  endfunction

  function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v,
                                                input logic [DIMW-1:0] hi);
    logic [DIMW-1:0] r;
    if (v == '0) begin
      r = DIMW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcce_mod.sv =====
// ----------------------------------------------------------------------------
// tcce_mod
// Radix-2 restoring remainder unit: 32-bit dividend modulo a narrow divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tcce_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tcce_pkg::SEEDW-1:0]   dividend,
  input  logic [tcce_pkg::NW-1:0]      divisor,
  output logic                         busy,
  output logic [tcce_pkg::NW-1:0]      rem
);

  localparam int SW = $clog2(tcce_pkg::SEEDW + 1);

  logic [tcce_pkg::SEEDW-1:0] dvd_r;
  logic [tcce_pkg::NW-1:0]    div_r;
  logic [tcce_pkg::NW-1:0]    rem_r;
  logic [SW-1:0]              cnt_r;
  logic                       busy_r;
  logic [tcce_pkg::NW:0]      trial;
  logic [tcce_pkg::NW:0]      diff;

  assign trial = {rem_r, dvd_r[tcce_pkg::SEEDW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SW'(tcce_pkg::SEEDW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      // remainder stays below the divisor, so it fits back in NW bits
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[tcce_pkg::NW-1:0];
      end else begin
        rem_r <= trial[tcce_pkg::NW-1:0];
      end
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/tcce_ctl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctl
// Controller: sequences rule loads, grid clears, collapse steps with
// propagation, and cell reads over the datapath.
// ----------------------------------------------------------------------------
module tcce_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  input  tcce_pkg::sts_t   sts,
  output tcce_pkg::cmd_t   cmd,
  output logic             in_stall
);

  tcce_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcce_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            tcce_pkg::FUNC_RULE:     state_nxt = tcce_pkg::ST_RULE;
            tcce_pkg::FUNC_CLEAR:    state_nxt = tcce_pkg::ST_CLR_GO;
            tcce_pkg::FUNC_COLLAPSE: state_nxt = tcce_pkg::ST_MIN_GO;
            default:                 state_nxt = tcce_pkg::ST_RD;
          endcase
        end
      end
      tcce_pkg::ST_RULE:    state_nxt = tcce_pkg::ST_DONE_GO;
      tcce_pkg::ST_CLR_GO:  state_nxt = tcce_pkg::ST_CLR;
      tcce_pkg::ST_CLR: begin
        if (!sts.scan_busy) state_nxt = tcce_pkg::ST_DONE_GO;
      end
      tcce_pkg::ST_MIN_GO:  state_nxt = tcce_pkg::ST_MIN;
      tcce_pkg::ST_MIN: begin
        if (!sts.scan_busy) begin
          state_nxt = sts.collapse_none ? tcce_pkg::ST_DONE_GO : tcce_pkg::ST_RND1;
        end
      end
      tcce_pkg::ST_RND1:    state_nxt = tcce_pkg::ST_MOD1;
      tcce_pkg::ST_MOD1: begin
        if (!sts.mod_busy) state_nxt = tcce_pkg::ST_PICK_GO;
      end
      tcce_pkg::ST_PICK_GO: state_nxt = tcce_pkg::ST_PICK;
      tcce_pkg::ST_PICK: begin
        if (!sts.scan_busy) state_nxt = tcce_pkg::ST_RND2;
      end
      tcce_pkg::ST_RND2:    state_nxt = tcce_pkg::ST_MOD2;
      tcce_pkg::ST_MOD2: begin
        if (!sts.mod_busy) state_nxt = tcce_pkg::ST_KTH_GO;
      end
      tcce_pkg::ST_KTH_GO:  state_nxt = tcce_pkg::ST_KTH;
      tcce_pkg::ST_KTH: begin
        if (sts.kth_last) state_nxt = tcce_pkg::ST_FIX;
      end
      tcce_pkg::ST_FIX:     state_nxt = tcce_pkg::ST_POP;
      tcce_pkg::ST_POP: begin
        state_nxt = sts.q_empty ? tcce_pkg::ST_DONE_GO : tcce_pkg::ST_POPQ;
      end
      tcce_pkg::ST_POPQ:    state_nxt = tcce_pkg::ST_POPC;
      tcce_pkg::ST_POPC:    state_nxt = tcce_pkg::ST_ADJ;
      tcce_pkg::ST_ADJ: begin
        if (!sts.adj_busy) state_nxt = tcce_pkg::ST_DIR;
      end
      tcce_pkg::ST_DIR: begin
        if (sts.nb_ok) begin
          state_nxt = tcce_pkg::ST_CHILD;
        end else if (sts.dir_last) begin
          state_nxt = tcce_pkg::ST_POP;
        end
      end
      tcce_pkg::ST_CHILD: begin
        if (sts.child_zero) begin
          state_nxt = tcce_pkg::ST_DONE_GO;
        end else if (sts.dir_last) begin
          state_nxt = tcce_pkg::ST_POP;
        end else begin
          state_nxt = tcce_pkg::ST_DIR;
        end
      end
      tcce_pkg::ST_RD:      state_nxt = tcce_pkg::ST_RDW;
      tcce_pkg::ST_RDW:     state_nxt = tcce_pkg::ST_DONE_GO;
      tcce_pkg::ST_DONE_GO: state_nxt = tcce_pkg::ST_DONE;
      tcce_pkg::ST_DONE: begin
        if (!sts.scan_busy) state_nxt = tcce_pkg::ST_EMIT;
      end
      tcce_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = tcce_pkg::ST_IDLE;
      end
      default: state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.scan_mode = tcce_pkg::SCAN_DONE;
    in_stall      = (state_r != tcce_pkg::ST_IDLE);
    case (state_r)
      tcce_pkg::ST_IDLE:    cmd.latch = in_valid;
      tcce_pkg::ST_RULE:    cmd.rule_wr = 1'b1;
      tcce_pkg::ST_CLR_GO: begin
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = tcce_pkg::SCAN_CLEAR;
        cmd.clear_fin  = 1'b1;
      end
      tcce_pkg::ST_CLR:     cmd.scan_mode = tcce_pkg::SCAN_CLEAR;
      tcce_pkg::ST_MIN_GO: begin
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = tcce_pkg::SCAN_MIN;
      end
      tcce_pkg::ST_MIN:     cmd.scan_mode = tcce_pkg::SCAN_MIN;
      tcce_pkg::ST_RND1:    cmd.rnd1 = 1'b1;
      tcce_pkg::ST_PICK_GO: begin
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = tcce_pkg::SCAN_PICK;
        cmd.pick_load  = 1'b1;
      end
      tcce_pkg::ST_PICK:    cmd.scan_mode = tcce_pkg::SCAN_PICK;
      tcce_pkg::ST_RND2:    cmd.rnd2 = 1'b1;
      tcce_pkg::ST_KTH_GO:  cmd.kth_load = 1'b1;
      tcce_pkg::ST_KTH:     cmd.kth_step = 1'b1;
      tcce_pkg::ST_FIX:     cmd.fix = 1'b1;
      tcce_pkg::ST_POP:     cmd.pop_issue = !sts.q_empty;
      tcce_pkg::ST_POPQ:    cmd.pop_take = 1'b1;
      tcce_pkg::ST_POPC:    cmd.adj_start = 1'b1;
      tcce_pkg::ST_DIR: begin
        cmd.child_issue = sts.nb_ok;
        cmd.dir_next    = !sts.nb_ok && !sts.dir_last;
      end
      tcce_pkg::ST_CHILD: begin
        cmd.child_update = 1'b1;
        cmd.dir_next     = !sts.child_zero && !sts.dir_last;
      end
      tcce_pkg::ST_RD:      cmd.rd_issue = 1'b1;
      tcce_pkg::ST_RDW:     cmd.rd_take = 1'b1;
      tcce_pkg::ST_DONE_GO: cmd.scan_start = 1'b1;
      tcce_pkg::ST_EMIT:    cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: configuration registers, cell and adjacency stores, pending
// queue, scan and adjacency engines, random generator and result register.
// ----------------------------------------------------------------------------
module tcce_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tcce_pkg::SEEDW-1:0]  cfg_data,
  input  tcce_pkg::in_req_t           in_data,
  input  logic                        out_stall,
  input  tcce_pkg::cmd_t              cmd,
  output tcce_pkg::sts_t              sts,
  output logic                        out_valid,
  output tcce_pkg::out_res_t          out_data
);

  localparam int MW   = tcce_pkg::MW;
  localparam int CW   = tcce_pkg::CW;
  localparam int AW   = tcce_pkg::AW;
  localparam int NW   = tcce_pkg::NW;
  localparam int TW   = tcce_pkg::TW;
  localparam int DIMW = tcce_pkg::DIMW;
  localparam int XYW  = $bits(tcce_pkg::xy_t);

  function automatic logic [AW-1:0] cell_index(input tcce_pkg::xy_t p,
                                               input logic [DIMW-1:0] w);
    logic [NW-1:0] s;
    s = NW'(p.y) * NW'(w) + NW'(p.x);
    return s[AW-1:0];
  endfunction

  // configuration
  logic [DIMW-1:0]            gw_r, gh_r, gt_r;
  logic [tcce_pkg::SEEDW-1:0] seed_r;
  logic [DIMW-1:0]            eff_w, eff_h, eff_t;
  logic [2*DIMW-1:0]          area;
  logic [NW-1:0]              n_cells;
  logic [MW:0]                full_wide;
  logic [MW-1:0]              full_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= tcce_pkg::RST_WIDTH;
      gh_r   <= tcce_pkg::RST_HEIGHT;
      gt_r   <= tcce_pkg::RST_TILES;
      seed_r <= tcce_pkg::RST_SEED;
    end else if (cfg_we) begin
      case (cfg_index)
        tcce_pkg::CFG_WIDTH:  gw_r <= cfg_data[DIMW-1:0];
        tcce_pkg::CFG_HEIGHT: gh_r <= cfg_data[DIMW-1:0];
        tcce_pkg::CFG_TILES:  gt_r <= cfg_data[DIMW-1:0];
        tcce_pkg::CFG_SEED:   seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w     = tcce_pkg::clamp_dim(gw_r, DIMW'(tcce_pkg::MAX_WIDTH));
  assign eff_h     = tcce_pkg::clamp_dim(gh_r, DIMW'(tcce_pkg::MAX_HEIGHT));
  assign eff_t     = tcce_pkg::clamp_dim(gt_r, DIMW'(tcce_pkg::MAX_TILES));
  assign area      = eff_w * eff_h;
  assign n_cells   = area[NW-1:0];
  assign full_wide = (MW+1)'(1) << eff_t;
  assign full_mask = MW'(full_wide - (MW+1)'(1));

  // request and result registers
  tcce_pkg::in_req_t req_r;
  logic [AW-1:0]     res_cell_r;
  logic [TW-1:0]     res_tile_r;
  logic [MW-1:0]     res_mask_r;
  logic [CW-1:0]     res_cnt_r;

  // stores
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [CW+MW-1:0] cell_wdata, cell_rdata;
  logic [CW-1:0] rd_cnt;
  logic [MW-1:0] rd_mask;

  assign rd_cnt  = cell_rdata[CW+MW-1:MW];
  assign rd_mask = cell_rdata[MW-1:0];

  tcce_ram #(.WIDTH(CW + MW), .DEPTH(tcce_pkg::MAX_CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  logic [TW-1:0] adj_t_r, adj_tq_r;
  logic          adj_iss_r, adj_vld_r;
  logic [MW-1:0] adj_rdata [tcce_pkg::NDIR];

  for (genvar d = 0; d < tcce_pkg::NDIR; d++) begin : g_adj
    tcce_ram #(.WIDTH(MW), .DEPTH(tcce_pkg::MAX_TILES)) u_adj (
      .clk   (clk),
      .we    (cmd.rule_wr && (req_r.rule_dir == 2'(d))),
      .waddr (req_r.rule_tile),
      .wdata (req_r.rule_mask),
      .raddr (adj_t_r),
      .rdata (adj_rdata[d])
    );
  end

  logic [AW-1:0]   qhead_r;
  logic [NW-1:0]   qlen_r;
  logic [tcce_pkg::MAX_CELLS-1:0] marks_r;
  logic            push_req, push_do;
  tcce_pkg::xy_t   push_xy, q_rdata;
  logic [AW-1:0]   q_waddr;
  logic [NW-1:0]   q_tail;

  assign q_tail  = NW'(qhead_r) + qlen_r;
  assign q_waddr = q_tail[AW-1:0];
  assign push_do = push_req && !marks_r[push_xy];

  tcce_ram #(.WIDTH(XYW), .DEPTH(tcce_pkg::MAX_CELLS)) u_queue (
    .clk   (clk),
    .we    (push_do),
    .waddr (q_waddr),
    .wdata (push_xy),
    .raddr (qhead_r),
    .rdata (q_rdata)
  );

  // scan engine: one cell address per cycle, data in the cycle after
  logic          scan_iss_r, scan_vld_r;
  logic [NW-1:0] scan_cnt_r;
  tcce_pkg::xy_t scan_xy_r, tag_xy_r;
  logic [CW-1:0] lowest_r;
  logic [NW-1:0] ties_r, pick_r;
  logic          found_r, notone_r;
  tcce_pkg::xy_t sel_r;
  logic [MW-1:0] sel_mask_r;
  logic [CW-1:0] sel_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_iss_r <= 1'b0;
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= scan_iss_r && (cmd.scan_mode != tcce_pkg::SCAN_CLEAR);
      if (cmd.scan_start) begin
        scan_iss_r <= 1'b1;
      end else if (scan_iss_r && (scan_cnt_r == n_cells - NW'(1))) begin
        scan_iss_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_xy_r <= scan_xy_r;
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      scan_xy_r  <= '0;
    end else if (scan_iss_r) begin
      scan_cnt_r <= scan_cnt_r + NW'(1);
      if ({1'b0, scan_xy_r.x} == eff_w - DIMW'(1)) begin
        scan_xy_r.x <= '0;
        scan_xy_r.y <= scan_xy_r.y + 1'b1;
      end else begin
        scan_xy_r.x <= scan_xy_r.x + 1'b1;
      end
    end
  end

  // random generator and remainder unit
  logic [tcce_pkg::SEEDW-1:0] rng_r, rng_step;
  logic                       mod_busy;
  logic [NW-1:0]              mod_rem;

  assign rng_step = tcce_pkg::xorshift32(rng_r);

  tcce_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rnd1 || cmd.rnd2),
    .dividend (rng_step),
    .divisor  (cmd.rnd1 ? ties_r : NW'(sel_cnt_r)),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // per-cell scan processing
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      case (cmd.scan_mode)
        tcce_pkg::SCAN_MIN: begin
          lowest_r <= '1;
          ties_r   <= '0;
        end
        tcce_pkg::SCAN_PICK: found_r  <= 1'b0;
        tcce_pkg::SCAN_DONE: notone_r <= 1'b0;
        default: ;
      endcase
    end else if (scan_vld_r) begin
      case (cmd.scan_mode)
        tcce_pkg::SCAN_MIN: begin
          if (rd_cnt > CW'(1)) begin
            if (rd_cnt < lowest_r) begin
              lowest_r <= rd_cnt;
              ties_r   <= NW'(1);
            end else if (rd_cnt == lowest_r) begin
              ties_r <= ties_r + NW'(1);
            end
          end
        end
        tcce_pkg::SCAN_PICK: begin
          if ((rd_cnt == lowest_r) && !found_r) begin
            if (pick_r == '0) begin
              found_r    <= 1'b1;
              sel_r      <= tag_xy_r;
              sel_mask_r <= rd_mask;
              sel_cnt_r  <= rd_cnt;
            end else begin
              pick_r <= pick_r - NW'(1);
            end
          end
        end
        tcce_pkg::SCAN_DONE: begin
          if (rd_cnt != CW'(1)) notone_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.pick_load) pick_r <= mod_rem;
  end

  // k-th candidate walk over the selected mask
  logic [TW-1:0] kbit_r, kcnt_r, tile_r;
  logic          kfound_r;

  always_ff @(posedge clk) begin
    if (cmd.kth_load) begin
      kbit_r   <= '0;
      kcnt_r   <= mod_rem[TW-1:0];
      kfound_r <= 1'b0;
      tile_r   <= '0;
    end else if (cmd.kth_step) begin
      kbit_r <= kbit_r + 1'b1;
      if (sel_mask_r[kbit_r] && !kfound_r) begin
        if (kcnt_r == '0) begin
          kfound_r <= 1'b1;
          tile_r   <= kbit_r;
        end else begin
          kcnt_r <= kcnt_r - 1'b1;
        end
      end
    end
  end

  // propagation: popped cell, allowed masks per direction, neighbor
  tcce_pkg::xy_t cur_r, child_r, nb_xy;
  logic [MW-1:0] cur_mask_r;
  logic [MW-1:0] allowed_r [tcce_pkg::NDIR];
  logic [1:0]    dir_r;
  logic          nb_ok;
  logic          ch_upd;
  logic [MW-1:0] ch_mask;
  logic [CW-1:0] ch_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_iss_r <= 1'b0;
      adj_vld_r <= 1'b0;
    end else begin
      adj_vld_r <= adj_iss_r;
      if (cmd.adj_start) begin
        adj_iss_r <= 1'b1;
      end else if (adj_iss_r && (adj_t_r == '1)) begin
        adj_iss_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    adj_tq_r <= adj_t_r;
    if (cmd.pop_take) cur_r <= q_rdata;
    if (cmd.child_issue) child_r <= nb_xy;
    if (cmd.dir_next) dir_r <= dir_r + 1'b1;
    if (cmd.adj_start) begin
      adj_t_r    <= '0;
      cur_mask_r <= rd_mask;
      dir_r      <= tcce_pkg::DIR_UP;
      for (int d = 0; d < tcce_pkg::NDIR; d++) begin
        allowed_r[d] <= '0;
      end
    end else begin
      if (adj_iss_r) adj_t_r <= adj_t_r + 1'b1;
      if (adj_vld_r && cur_mask_r[adj_tq_r]) begin
        for (int d = 0; d < tcce_pkg::NDIR; d++) begin
          allowed_r[d] <= allowed_r[d] | adj_rdata[d];
        end
      end
    end
  end

  always_comb begin
    nb_xy = cur_r;
    nb_ok = 1'b0;
    case (dir_r)
      tcce_pkg::DIR_UP: begin
        nb_ok   = (cur_r.y != '0);
        nb_xy.y = cur_r.y - 1'b1;
      end
      tcce_pkg::DIR_DOWN: begin
        nb_ok   = (DIMW'(cur_r.y) + DIMW'(1) < eff_h);
        nb_xy.y = cur_r.y + 1'b1;
      end
      tcce_pkg::DIR_LEFT: begin
        nb_ok   = (cur_r.x != '0);
        nb_xy.x = cur_r.x - 1'b1;
      end
      tcce_pkg::DIR_RIGHT: begin
        nb_ok   = (DIMW'(cur_r.x) + DIMW'(1) < eff_w);
        nb_xy.x = cur_r.x + 1'b1;
      end
      default: ;
    endcase
  end

  assign ch_upd  = (rd_cnt > CW'(1));
  assign ch_mask = rd_mask & allowed_r[dir_r];
  assign ch_cnt  = tcce_pkg::popcount16(ch_mask);

  // cell store ports
  always_comb begin
    cell_raddr = req_r.read_cell;
    if (scan_iss_r) begin
      cell_raddr = scan_cnt_r[AW-1:0];
    end else if (cmd.pop_take) begin
      cell_raddr = cell_index(q_rdata, eff_w);
    end else if (cmd.child_issue) begin
      cell_raddr = cell_index(nb_xy, eff_w);
    end else if (cmd.rd_issue) begin
      cell_raddr = req_r.read_cell;
    end
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = scan_cnt_r[AW-1:0];
    cell_wdata = {eff_t, full_mask};
    push_req   = 1'b0;
    push_xy    = sel_r;
    if (scan_iss_r && (cmd.scan_mode == tcce_pkg::SCAN_CLEAR)) begin
      cell_we = 1'b1;
    end else if (cmd.fix) begin
      cell_we    = 1'b1;
      cell_waddr = cell_index(sel_r, eff_w);
      cell_wdata = {CW'(1), MW'(1) << tile_r};
      push_req   = 1'b1;
    end else if (cmd.child_update && ch_upd) begin
      cell_we    = 1'b1;
      cell_waddr = cell_index(child_r, eff_w);
      cell_wdata = {ch_cnt, ch_mask};
      push_req   = (ch_cnt < rd_cnt);
      push_xy    = child_r;
    end
  end

  // queue, generator and contradiction flag
  logic contra_r;
  logic flush;

  assign flush = cmd.clear_fin || (cmd.child_update && ch_upd && (ch_cnt == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qhead_r  <= '0;
      qlen_r   <= '0;
      marks_r  <= '0;
      rng_r    <= tcce_pkg::RST_SEED;
      contra_r <= 1'b0;
    end else begin
      if (cmd.pop_issue) begin
        qhead_r <= qhead_r + 1'b1;
        qlen_r  <= qlen_r - NW'(1);
      end
      if (cmd.pop_take) marks_r[q_rdata] <= 1'b0;
      if (push_do) begin
        marks_r[push_xy] <= 1'b1;
        qlen_r           <= qlen_r + NW'(1);
      end
      if (cmd.rnd1 || cmd.rnd2) rng_r <= rng_step;
      if (cmd.child_update && ch_upd && (ch_cnt == '0)) contra_r <= 1'b1;
      // empty the queue last so it wins over a push in the same cycle
      if (flush) begin
        qhead_r <= '0;
        qlen_r  <= '0;
        marks_r <= '0;
      end
      if (cmd.clear_fin) begin
        rng_r    <= seed_r;
        contra_r <= 1'b0;
      end
    end
  end

  // request capture and result fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r      <= in_data;
      res_cell_r <= '0;
      res_tile_r <= '0;
      res_mask_r <= '0;
      res_cnt_r  <= '0;
    end else if (cmd.fix) begin
      res_cell_r <= cell_index(sel_r, eff_w);
      res_tile_r <= tile_r;
    end else if (cmd.rd_take) begin
      res_cell_r <= req_r.read_cell;
      if (NW'(req_r.read_cell) < n_cells) begin
        res_mask_r <= rd_mask;
        res_cnt_r  <= rd_cnt;
        res_tile_r <= tcce_pkg::lowest_bit(rd_mask);
      end
    end
  end

  // output register
  logic               out_valid_r;
  tcce_pkg::out_res_t out_data_r;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.cell_out      <= res_cell_r;
      out_data_r.tile_out      <= res_tile_r;
      out_data_r.mask_out      <= res_mask_r;
      out_data_r.count_out     <= res_cnt_r;
      out_data_r.all_collapsed <= !notone_r;
      out_data_r.contradiction <= contra_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.scan_busy     = scan_iss_r || scan_vld_r;
  assign sts.mod_busy      = mod_busy;
  assign sts.adj_busy      = adj_iss_r || adj_vld_r;
  assign sts.kth_last      = (kbit_r == '1);
  assign sts.q_empty       = (qlen_r == '0);
  assign sts.nb_ok         = nb_ok;
  assign sts.dir_last      = (dir_r == tcce_pkg::DIR_RIGHT);
  assign sts.child_zero    = ch_upd && (ch_cnt == '0);
  assign sts.collapse_none = contra_r || (ties_r == '0);
  assign sts.out_free      = out_free;

endmodule

// ===== rtl/tile_constraint_collapse_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tile_constraint_collapse_engine_unit
// Wave-function-collapse engine over a grid of up to 16 x 16 cells.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall and carry one of four functions: load
// an adjacency rule, clear the grid, run one collapse step, or read a cell.
// Every request gives exactly one result on out_valid/out_stall, which also
// reports whether all cells are collapsed and whether a contradiction hit.
// Geometry, tile count and seed sit on the cfg_ write port; write them only
// while the block is idle.
// Each request ends with a status scan over the n = width * height cells.
// A collapse step runs two cell scans, two remainder runs and a candidate
// walk over the selected cell's mask, then propagation, which for each
// popped cell sweeps the adjacency store over all tiles and accesses the
// cell store once per neighbor inside the grid.
// One request is in flight at a time; in_stall is high from acceptance until
// the result is loaded into the output register, and a new request is taken
// while that result waits on out_stall. The output register holds its data
// under out_stall and a finished request waits for it to drain.
// Reset restores the default geometry and seed, empties the pending queue and
// clears the contradiction flag; cells read as undefined until a grid clear.
// ----------------------------------------------------------------------------
module tile_constraint_collapse_engine_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcce_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcce_pkg::out_res_t          out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tcce_pkg::SEEDW-1:0]  cfg_data
);

  tcce_pkg::cmd_t cmd;
  tcce_pkg::sts_t sts;

  tcce_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tcce_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but block did not go busy");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_mod_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rnd1 || cmd.rnd2) |-> !sts.mod_busy)
    else $error("remainder unit restarted while busy");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tile_constraint_collapse_engine_unit: a queue-fed
// driver sends rule, clear, collapse and read requests with random gaps, a
// local predictor of the grid computes each result, and a monitor under
// random output stall checks every result field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tcce_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tcce_pkg::out_res_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = tcce_pkg::CFG_WIDTH;
  logic [31:0]        cfg_data = '0;

  tile_constraint_collapse_engine_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // grid model
  logic [15:0] cand_mask [tcce_pkg::MAX_CELLS];
  int          cand_cnt [tcce_pkg::MAX_CELLS];
  logic [15:0] adj_tab [tcce_pkg::MAX_TILES * 4];
  logic [31:0] rng_word = 32'd1;
  int          pend_q[$];
  bit          pend_mark [tcce_pkg::MAX_CELLS];
  bit          contra = 1'b0;
  int          grid_w = 10, grid_h = 10, grid_t = 16;
  logic [31:0] grid_seed = 32'd1;

  tcce_pkg::in_req_t  req_fifo[$];
  tcce_pkg::out_res_t expected_results[$];
  int          fail_count = 0;
  int          idle_on = 1;
  int          in_gap = 0;
  int          stall_hold = 0;

  // planner view of the geometry
  int          valid_cells = 0;
  int          item_total = 0;

  function automatic int eff_dim(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int cell_total();
    return eff_dim(grid_w, tcce_pkg::MAX_WIDTH) * eff_dim(grid_h, tcce_pkg::MAX_HEIGHT);
  endfunction

  function automatic logic [31:0] step_rng();
    logic [31:0] x;
    x = rng_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_word = x;
    return x;
  endfunction

  function automatic int nth_set_bit(input logic [15:0] m, input int k);
    for (int b = 0; b < 16; b++) begin
      if (m[b]) begin
        if (k == 0) return b;
        k--;
      end
    end
    return 0;
  endfunction

  function automatic int ones(input logic [15:0] m);
    int n;
    n = 0;
    for (int b = 0; b < 16; b++) n += m[b];
    return n;
  endfunction

  function automatic void mark_pending(input int c);
    if (!pend_mark[c]) begin
      pend_mark[c] = 1'b1;
      pend_q.push_back(c);
    end
  endfunction

  function automatic void settle_constraints();
    int w, h, c, x, y, nx, ny, child, nc;
    logic [15:0] allowed, nm;
    w = eff_dim(grid_w, tcce_pkg::MAX_WIDTH);
    h = eff_dim(grid_h, tcce_pkg::MAX_HEIGHT);
    while (pend_q.size() > 0) begin
      c = pend_q.pop_front();
      pend_mark[c] = 1'b0;
      for (int d = 0; d < 4; d++) begin
        x = c % w;
        y = c / w;
        nx = x;
        ny = y;
        allowed = '0;
        for (int t = 0; t < tcce_pkg::MAX_TILES; t++)
          if (cand_mask[c][t]) allowed |= adj_tab[t * 4 + d];
        if (d == tcce_pkg::DIR_UP) begin
          if (y == 0) continue;
          ny = y - 1;
        end else if (d == tcce_pkg::DIR_DOWN) begin
          if (y + 1 >= h) continue;
          ny = y + 1;
        end else if (d == tcce_pkg::DIR_LEFT) begin
          if (x == 0) continue;
          nx = x - 1;
        end else begin
          if (x + 1 >= w) continue;
          nx = x + 1;
        end
        child = ny * w + nx;
        if (child >= tcce_pkg::MAX_CELLS || cand_cnt[child] <= 1) continue;
        nm = cand_mask[child] & allowed;
        nc = ones(nm);
        if (nc < cand_cnt[child]) mark_pending(child);
        cand_mask[child] = nm;
        cand_cnt[child] = nc;
        if (nc == 0) begin
          // contradiction: drop everything still pending
          contra = 1'b1;
          pend_q.delete();
          foreach (pend_mark[i]) pend_mark[i] = 1'b0;
          return;
        end
      end
    end
  endfunction

  function automatic tcce_pkg::out_res_t apply_request(input tcce_pkg::in_req_t r);
    tcce_pkg::out_res_t res;
    int n, t, lowest, ties, pick, sel, k;
    bit done;
    res = '0;
    n = cell_total();
    case (r.func)
      tcce_pkg::FUNC_RULE: adj_tab[r.rule_tile * 4 + r.rule_dir] = r.rule_mask;
      tcce_pkg::FUNC_CLEAR: begin
        t = eff_dim(grid_t, tcce_pkg::MAX_TILES);
        for (int i = 0; i < n; i++) begin
          cand_mask[i] = 16'((32'd1 << t) - 1);
          cand_cnt[i] = t;
        end
        rng_word = grid_seed;
        pend_q.delete();
        foreach (pend_mark[i]) pend_mark[i] = 1'b0;
        contra = 1'b0;
      end
      tcce_pkg::FUNC_COLLAPSE: begin
        lowest = 1000;
        ties = 0;
        for (int i = 0; i < n; i++) begin
          if (cand_cnt[i] > 1) begin
            if (cand_cnt[i] < lowest) begin
              lowest = cand_cnt[i];
              ties = 1;
            end else if (cand_cnt[i] == lowest) ties++;
          end
        end
        if (!contra && ties > 0) begin
          pick = int'(step_rng() % ties);
          sel = 0;
          for (int i = 0; i < n; i++) begin
            if (cand_cnt[i] == lowest) begin
              if (pick == 0) begin
                sel = i;
                break;
              end
              pick--;
            end
          end
          k = int'(step_rng() % cand_cnt[sel]);
          t = nth_set_bit(cand_mask[sel], k);
          cand_mask[sel] = 16'd1 << t;
          cand_cnt[sel] = 1;
          mark_pending(sel);
          settle_constraints();
          res.cell_out = 8'(sel);
          res.tile_out = 4'(t);
        end
      end
      default: begin
        res.cell_out = r.read_cell;
        if (r.read_cell < n) begin
          res.mask_out = cand_mask[r.read_cell];
          res.count_out = 5'(cand_cnt[r.read_cell]);
          res.tile_out = 4'(nth_set_bit(cand_mask[r.read_cell], 0));
        end
      end
    endcase
    done = 1'b1;
    for (int i = 0; i < n; i++) if (cand_cnt[i] != 1) done = 1'b0;
    res.all_collapsed = done;
    res.contradiction = contra;
    return res;
  endfunction

  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_on || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_fifo.size() > 0) begin
        in_data <= req_fifo.pop_front();
        in_valid <= 1'b1;
        in_gap = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_results.push_back(apply_request(in_data));
  end

  // monitor and output stall
  always @(posedge clk) begin
    tcce_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          fail_count++;
        end
      end
    end
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_hold = draw_gap();
      out_stall <= idle_on && ($urandom_range(0, 2) == 0);
    end
  end

  function automatic tcce_pkg::in_req_t make_req(input logic [1:0] f);
    tcce_pkg::in_req_t r;
    r = tcce_pkg::in_req_t'($urandom);
    r.func = f;
    return r;
  endfunction

  task automatic send(input tcce_pkg::in_req_t r);
    req_fifo.push_back(r);
    item_total++;
    if (r.func == tcce_pkg::FUNC_CLEAR && cell_total() > valid_cells) valid_cells = cell_total();
  endtask

  task automatic send_rule(input int tile, input int dir, input logic [15:0] m);
    tcce_pkg::in_req_t r;
    r = make_req(tcce_pkg::FUNC_RULE);
    r.rule_tile = 4'(tile);
    r.rule_dir = 2'(dir);
    r.rule_mask = m;
    send(r);
  endtask

  task automatic send_read(input int c);
    tcce_pkg::in_req_t r;
    r = make_req(tcce_pkg::FUNC_READ);
    r.read_cell = 8'(c);
    send(r);
  endtask

  function automatic logic [15:0] dense_mask();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hffff;
    if (p < 4) return 16'($urandom);
    return 16'($urandom | $urandom | $urandom);
  endfunction

  // hold until the block is idle and every result is in
  task automatic drain();
    while (req_fifo.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tcce_pkg::CFG_WIDTH:  grid_w = int'(val[4:0]);
      tcce_pkg::CFG_HEIGHT: grid_h = int'(val[4:0]);
      tcce_pkg::CFG_TILES:  grid_t = int'(val[4:0]);
      default:              grid_seed = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int t, input logic [31:0] s);
    drain();
    write_reg(tcce_pkg::CFG_WIDTH, 32'(w));
    write_reg(tcce_pkg::CFG_HEIGHT, 32'(h));
    write_reg(tcce_pkg::CFG_TILES, 32'(t));
    write_reg(tcce_pkg::CFG_SEED, s);
    idle_on = ($urandom_range(0, 4) != 0);
    // a larger grid exposes cells that were never cleared
    if (cell_total() > valid_cells) send(make_req(tcce_pkg::FUNC_CLEAR));
  endtask

  task automatic random_burst(input int count);
    int p, n;
    n = cell_total();
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 50) send(make_req(tcce_pkg::FUNC_COLLAPSE));
      else if (p < 75) begin
        if ($urandom_range(0, 3) == 0) send_read($urandom_range(0, 255));
        else send_read($urandom_range(0, (n + 2 > 255) ? 255 : n + 2));
      end else if (p < 85) send(make_req(tcce_pkg::FUNC_CLEAR));
      else send_rule($urandom_range(0, 15), $urandom_range(0, 3), dense_mask());
    end
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // default geometry: clear first, then fill the whole adjacency store
    send(make_req(tcce_pkg::FUNC_CLEAR));
    for (int t = 0; t < tcce_pkg::MAX_TILES; t++)
      for (int d = 0; d < 4; d++)
        send_rule(t, d, (t == 0 && d == tcce_pkg::DIR_UP) ? 16'hffff : dense_mask());
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send_read(0);
    send_read(99);
    send_read(100);
    send_read(255);
    send(make_req(tcce_pkg::FUNC_CLEAR));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));

    // saturated geometry without a clear: reinterpret the old cells
    set_geometry(0, 31, 31, 32'hffff_ffff);
    send_read(15);
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send(make_req(tcce_pkg::FUNC_CLEAR));
    random_burst(6);

    // single tile: nothing to collapse; zero seed
    set_geometry(4, 4, 1, 32'h0);
    send(make_req(tcce_pkg::FUNC_CLEAR));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send_read(5);
    set_geometry(4, 4, 0, 32'h0);
    send(make_req(tcce_pkg::FUNC_CLEAR));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));

    // forced contradiction, then a step that must change nothing
    set_geometry(3, 3, 2, 32'h1234_5678);
    send(make_req(tcce_pkg::FUNC_CLEAR));
    for (int d = 0; d < 4; d++) begin
      send_rule(0, d, 16'h0000);
      send_rule(1, d, 16'h0000);
    end
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send(make_req(tcce_pkg::FUNC_COLLAPSE));
    send_read(4);
    for (int d = 0; d < 4; d++) begin
      send_rule(0, d, dense_mask());
      send_rule(1, d, dense_mask());
    end

    // full size grid, once
    set_geometry(16, 31, 16, 32'($urandom));
    send(make_req(tcce_pkg::FUNC_CLEAR));
    random_burst(8);

    while (item_total < 280) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 31);
        h = $urandom_range(0, 8);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
      end
      set_geometry(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(2, 8),
                   ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom));
      if ($urandom_range(0, 1) == 0) send(make_req(tcce_pkg::FUNC_CLEAR));
      random_burst($urandom_range(15, 40));
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("** tile_constraint_collapse_engine_unit: PASSED **");
    end else begin
      $display("** tile_constraint_collapse_engine_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("%0t: timeout", $time);
    $display("** tile_constraint_collapse_engine_unit: FAILED **");
    $finish;
  end

endmodule

// ===== tile_constraint_collapse_engine_unit.f =====
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_mod.sv
rtl/tcce_ctl.sv
rtl/tcce_dp.sv
rtl/tile_constraint_collapse_engine_unit.sv
verif/testbench.sv
